// ===== rtl/core/matrix3_inverse_assert.svh =====
// ----------------------------------------------------------------------------
// matrix3_inverse assertion macros
// Shared property forms for the checker of the 3x3 inverse block.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH

// same-cycle implication, held off during reset
`define MI3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix3_inverse check failed");

// next-cycle implication, held off during reset
`define MI3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix3_inverse check failed");

`endif

// ===== rtl/core/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Types, widths and index tables shared by the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int DW      = 32;          // Q16.16 entry width
    localparam int NE      = 9;           // entries per matrix
    localparam int CW      = 65;          // cofactor width, Q33.32 signed
    localparam int NW      = 96;          // numerator / divisor magnitude width
    localparam int QB      = 33;          // quotient bits kept before saturation
    localparam int ST_DET  = 6;           // stage holding |det|
    localparam int ST_LAST = ST_DET + 1 + QB;
    localparam int NST     = ST_LAST + 1; // pipeline stages before output reg

    typedef logic signed [DW-1:0] entry_t;

    typedef struct packed {
        logic signed [31:0] in_c0_r0;
        logic signed [31:0] in_c0_r1;
        logic signed [31:0] in_c0_r2;
        logic signed [31:0] in_c1_r0;
        logic signed [31:0] in_c1_r1;
        logic signed [31:0] in_c1_r2;
        logic signed [31:0] in_c2_r0;
        logic signed [31:0] in_c2_r1;
        logic signed [31:0] in_c2_r2;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_c0_r0;
        logic signed [31:0] out_c0_r1;
        logic signed [31:0] out_c0_r2;
        logic signed [31:0] out_c1_r0;
        logic signed [31:0] out_c1_r1;
        logic signed [31:0] out_c1_r2;
        logic signed [31:0] out_c2_r0;
        logic signed [31:0] out_c2_r1;
        logic signed [31:0] out_c2_r2;
        logic               invertible;
    } out_item_t;

    // cofactor k = s[a]*s[b] - s[c]*s[d], flat index = col*3 + row
    localparam logic [3:0] COF_TERMS [NE][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
    };

endpackage

// ===== rtl/core/mi3_cof.sv =====
// ----------------------------------------------------------------------------
// mi3_cof
// One cofactor lane: two products, difference, then magnitude and sign
// delayed to line up with the determinant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_cof (
    input  logic                        clk,
    input  logic [mi3_pkg::ST_DET-1:0]  en,
    input  mi3_pkg::entry_t             a,
    input  mi3_pkg::entry_t             b,
    input  mi3_pkg::entry_t             c,
    input  mi3_pkg::entry_t             d,
    output logic signed [mi3_pkg::CW-1:0] cof,
    output logic [63:0]                 mag,
    output logic                        neg
);

    localparam int ND = mi3_pkg::ST_DET - 2;

    logic signed [63:0]              p_reg;
    logic signed [63:0]              q_reg;
    logic signed [mi3_pkg::CW-1:0]   cof_reg;
    logic [mi3_pkg::CW-1:0]          cof_abs;
    logic [63:0]                     mag_reg [ND];
    logic                            neg_reg [ND];

    assign cof_abs = cof_reg[mi3_pkg::CW-1] ? -cof_reg : cof_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg <= a * b;
            q_reg <= c * d;
        end
        if (en[1])
        begin
            cof_reg <= {p_reg[63], p_reg} - {q_reg[63], q_reg};
        end
        if (en[2])
        begin
            mag_reg[0] <= cof_abs[63:0];
            neg_reg[0] <= cof_reg[mi3_pkg::CW-1];
        end
        for (int j = 1; j < ND; j++)
        begin
            if (en[2+j])
            begin
                mag_reg[j] <= mag_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    assign cof = cof_reg;
    assign mag = mag_reg[ND-1];
    assign neg = neg_reg[ND-1];

endmodule

// ===== rtl/core/mi3_det.sv =====
// ----------------------------------------------------------------------------
// mi3_det
// Determinant as the first row dotted with the first adjugate column,
// split into 32-bit partial products; gives |det|, its sign and nonzero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_det (
    input  logic                          clk,
    input  logic [mi3_pkg::ST_DET-1:0]    en,
    input  mi3_pkg::entry_t               m [3],
    input  logic signed [mi3_pkg::CW-1:0] cof [3],
    output logic [mi3_pkg::NW-1:0]        dmag,
    output logic                          dneg,
    output logic                          nz
);

    mi3_pkg::entry_t      m1_reg [3];
    mi3_pkg::entry_t      m2_reg [3];
    logic signed [64:0]   plo_reg [3];
    logic signed [64:0]   phi_reg [3];
    logic signed [66:0]   slo_reg;
    logic signed [66:0]   shi_reg;
    logic signed [98:0]   det_reg;
    logic [98:0]          det_abs;
    logic [mi3_pkg::NW-1:0] dmag_reg;
    logic                 dneg_reg;
    logic                 nz_reg;

    assign det_abs = det_reg[98] ? -det_reg : det_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (en[0])
            begin
                m1_reg[j] <= m[j];
            end
            if (en[1])
            begin
                m2_reg[j] <= m1_reg[j];
            end
            if (en[2])
            begin
                plo_reg[j] <= m2_reg[j] * $signed({1'b0, cof[j][31:0]});
                phi_reg[j] <= m2_reg[j] * $signed(cof[j][64:32]);
            end
        end
        if (en[3])
        begin
            slo_reg <= plo_reg[0] + plo_reg[1] + plo_reg[2];
            shi_reg <= phi_reg[0] + phi_reg[1] + phi_reg[2];
        end
        if (en[4])
        begin
            det_reg <= (shi_reg <<< 32) + slo_reg;
        end
        if (en[5])
        begin
            dmag_reg <= det_abs[mi3_pkg::NW-1:0];
            dneg_reg <= det_reg[98];
            nz_reg   <= (det_reg != '0);
        end
    end

    assign dmag = dmag_reg;
    assign dneg = dneg_reg;
    assign nz   = nz_reg;

endmodule

// ===== rtl/core/mi3_div.sv =====
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage, for
// (|cofactor| << 32) / |det| with an up-front overflow check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_div (
    input  logic                        clk,
    input  logic [mi3_pkg::QB:0]        en,
    input  logic [63:0]                 nmag,
    input  logic                        neg_in,
    input  logic [mi3_pkg::NW-1:0]      dmag,
    output logic [mi3_pkg::QB-1:0]      quo,
    output logic                        sat,
    output logic                        neg
);

    localparam int QB = mi3_pkg::QB;
    localparam int NW = mi3_pkg::NW;
    localparam int TW = NW + QB;

    logic [NW-1:0] r_reg   [QB+1];
    logic [NW-1:0] d_reg   [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          sat_reg [QB+1];
    logic          neg_reg [QB+1];

    logic [TW-1:0] dsh  [QB];
    logic [TW:0]   diff [QB];
    logic [NW-1:0] num;

    assign num = {nmag, 32'b0};

    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            dsh[k]  = {{QB{1'b0}}, d_reg[k]} << (QB - 1 - k);
            diff[k] = {1'b0, {QB{1'b0}}, r_reg[k]} - {1'b0, dsh[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]   <= num;
            d_reg[0]   <= dmag;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_in;
            // quotient of 2^QB or more never fits
            sat_reg[0] <= ({{QB{1'b0}}, num} >= {dmag, {QB{1'b0}}});
        end
        for (int k = 0; k < QB; k++)
        begin
            if (en[k+1])
            begin
                r_reg[k+1]   <= diff[k][TW] ? r_reg[k] : diff[k][NW-1:0];
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ~diff[k][TW]};
                d_reg[k+1]   <= d_reg[k];
                sat_reg[k+1] <= sat_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign quo = q_reg[QB];
    assign sat = sat_reg[QB];
    assign neg = neg_reg[QB];

endmodule

// ===== rtl/core/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a 3x3 Q16.16 matrix via adjugate over determinant.
// ----------------------------------------------------------------------------
// Takes one matrix per clock and returns one inverse per clock while the
// output is not stalled. Nine lanes each form one cofactor and divide it by
// the determinant in a 33-stage restoring divider, one quotient bit per
// stage; that divider sets the latency. A stall at the output first fills
// the empty stages, so input is held off only when the whole pipeline is
// occupied. Singular matrices give invertible 0 and zeros.
`timescale 1ns / 1ps

module matrix3_inverse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mat_valid,
    output logic               mat_stall,
    input  mi3_pkg::in_item_t  mat,
    output logic               inv_valid,
    input  logic               inv_stall,
    output mi3_pkg::out_item_t inv
);

    localparam int NE      = mi3_pkg::NE;
    localparam int NST     = mi3_pkg::NST;
    localparam int ST_DET  = mi3_pkg::ST_DET;
    localparam int ST_LAST = mi3_pkg::ST_LAST;
    localparam int QB      = mi3_pkg::QB;

    logic [NST:0]              en;
    logic [NST-1:0]            vld_reg;
    logic [ST_LAST-ST_DET-1:0] nz_reg;
    mi3_pkg::entry_t           mat_arr [NE];
    mi3_pkg::entry_t           s_reg   [NE];

    logic signed [mi3_pkg::CW-1:0] cof   [NE];
    logic [63:0]                   cmag  [NE];
    logic                          cneg  [NE];
    logic [QB-1:0]                 quo   [NE];
    logic                          qsat  [NE];
    logic                          qneg  [NE];
    logic [31:0]                   res   [NE];

    mi3_pkg::entry_t               det_m   [3];
    logic signed [mi3_pkg::CW-1:0] det_cof [3];
    logic [mi3_pkg::NW-1:0]        dmag;
    logic                          dneg;
    logic                          dnz;

    logic                          inv_valid_reg;
    mi3_pkg::out_item_t            inv_reg;
    mi3_pkg::out_item_t            inv_next;

    function automatic logic [31:0] clip(input logic [QB-1:0] q, input logic ovf,
                                         input logic neg);
        logic [QB-1:0] nq;
        nq = -q;
        if (neg)
        begin
            clip = (ovf || q > {1'b0, 32'h8000_0000}) ? 32'h8000_0000 : nq[31:0];
        end
        else
        begin
            clip = (ovf || q[QB-1] || q[31]) ? 32'h7FFF_FFFF : q[31:0];
        end
    endfunction

    // stage i moves when it is empty or the next stage moves
    always_comb
    begin
        en[NST] = !inv_valid_reg || !inv_stall;
        for (int i = NST - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign mat_stall = !en[0];

    always_comb
    begin
        mat_arr[0] = mat.in_c0_r0;
        mat_arr[1] = mat.in_c0_r1;
        mat_arr[2] = mat.in_c0_r2;
        mat_arr[3] = mat.in_c1_r0;
        mat_arr[4] = mat.in_c1_r1;
        mat_arr[5] = mat.in_c1_r2;
        mat_arr[6] = mat.in_c2_r0;
        mat_arr[7] = mat.in_c2_r1;
        mat_arr[8] = mat.in_c2_r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            inv_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= mat_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (en[NST])
            begin
                inv_valid_reg <= vld_reg[NST-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < NE; k++)
            begin
                s_reg[k] <= mat_arr[k];
            end
        end
        if (en[ST_DET+1])
        begin
            nz_reg[0] <= dnz;
        end
        for (int i = 1; i < ST_LAST - ST_DET; i++)
        begin
            if (en[ST_DET+1+i])
            begin
                nz_reg[i] <= nz_reg[i-1];
            end
        end
        if (en[NST])
        begin
            inv_reg <= inv_next;
        end
    end

    for (genvar k = 0; k < NE; k++)
    begin : g_lane
        mi3_cof u_cof (
            .clk (clk),
            .en  (en[ST_DET:1]),
            .a   (s_reg[mi3_pkg::COF_TERMS[k][0]]),
            .b   (s_reg[mi3_pkg::COF_TERMS[k][1]]),
            .c   (s_reg[mi3_pkg::COF_TERMS[k][2]]),
            .d   (s_reg[mi3_pkg::COF_TERMS[k][3]]),
            .cof (cof[k]),
            .mag (cmag[k]),
            .neg (cneg[k])
        );

        mi3_div u_div (
            .clk    (clk),
            .en     (en[ST_LAST:ST_DET+1]),
            .nmag   (cmag[k]),
            .neg_in (cneg[k] ^ dneg),
            .dmag   (dmag),
            .quo    (quo[k]),
            .sat    (qsat[k]),
            .neg    (qneg[k])
        );

        assign res[k] = nz_reg[ST_LAST-ST_DET-1] ? clip(quo[k], qsat[k], qneg[k]) : 32'h0;
    end

    // det = s00*C00 + s01*C10 + s02*C20 (first row, first adjugate column)
    assign det_m[0]   = s_reg[0];
    assign det_m[1]   = s_reg[3];
    assign det_m[2]   = s_reg[6];
    assign det_cof[0] = cof[0];
    assign det_cof[1] = cof[1];
    assign det_cof[2] = cof[2];

    mi3_det u_det (
        .clk  (clk),
        .en   (en[ST_DET:1]),
        .m    (det_m),
        .cof  (det_cof),
        .dmag (dmag),
        .dneg (dneg),
        .nz   (dnz)
    );

    always_comb
    begin
        inv_next.out_c0_r0  = res[0];
        inv_next.out_c0_r1  = res[1];
        inv_next.out_c0_r2  = res[2];
        inv_next.out_c1_r0  = res[3];
        inv_next.out_c1_r1  = res[4];
        inv_next.out_c1_r2  = res[5];
        inv_next.out_c2_r0  = res[6];
        inv_next.out_c2_r1  = res[7];
        inv_next.out_c2_r2  = res[8];
        inv_next.invertible = nz_reg[ST_LAST-ST_DET-1];
    end

    assign inv_valid = inv_valid_reg;
    assign inv       = inv_reg;

endmodule

// ===== rtl/core/matrix3_inverse_chk.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_chk
// Port-level checks for the 3x3 inverse block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix3_inverse_assert.svh"

module matrix3_inverse_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               mat_valid,
    input logic               mat_stall,
    input logic               inv_valid,
    input logic               inv_stall,
    input mi3_pkg::out_item_t inv
);

    // input is only held off when a result is waiting
    `MI3_ASSERT_NOW(a_stall_needs_result, mat_stall, inv_valid)

    // a singular item carries an all-zero matrix
    `MI3_ASSERT_NOW(a_singular_zero, inv_valid && !inv.invertible, inv[288:1] == '0)

    `MI3_ASSERT_NEXT(a_valid_holds, inv_valid && inv_stall, inv_valid)

    `MI3_ASSERT_NEXT(a_item_holds, inv_valid && inv_stall, $stable(inv))

endmodule

bind matrix3_inverse matrix3_inverse_chk u_chk (.*);

// ===== tb/sv/tb_matrix3_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3_inverse
// Self-checking bench for the 3x3 Q16.16 inverse: a directed table, then
// random matrices (general, small-valued, singular, diagonal), with random
// gaps on both handshakes except in the last phase. Every result is checked
// against a wide-integer adjugate/determinant predictor, in order.
// ----------------------------------------------------------------------------

module tb_matrix3_inverse;

    typedef struct {
        mi3_pkg::in_item_t  m;
        bit                 known;
        mi3_pkg::out_item_t want;
    } row_t;

    // determinant terms, flat index = col*3 + row: three added, three subtracted
    localparam int SARRUS [6][3] = '{
        '{0, 4, 8}, '{1, 5, 6}, '{3, 7, 2},
        '{4, 2, 6}, '{0, 5, 7}, '{1, 3, 8}
    };
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    logic               clk;
    logic               rst_n;
    logic               mat_valid;
    logic               mat_stall;
    mi3_pkg::in_item_t  mat;
    logic               inv_valid;
    logic               inv_stall;
    mi3_pkg::out_item_t inv;

    mi3_pkg::out_item_t inverse_q[$];
    int                 errors;
    int                 phase;

    matrix3_inverse u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat),
        .inv_valid (inv_valid),
        .inv_stall (inv_stall),
        .inv       (inv)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic mi3_pkg::in_item_t pack_mat(logic [31:0] e0, e1, e2, e3, e4, e5, e6,
                                                   e7, e8);
        return {e0, e1, e2, e3, e4, e5, e6, e7, e8};
    endfunction

    function automatic mi3_pkg::out_item_t pack_inv(logic [31:0] e0, e1, e2, e3, e4, e5, e6,
                                                    e7, e8, logic ok);
        return {e0, e1, e2, e3, e4, e5, e6, e7, e8, ok};
    endfunction

    function automatic mi3_pkg::out_item_t predict_inverse(mi3_pkg::in_item_t m);
        logic [287:0]        v;
        logic signed [31:0]  s [9];
        logic signed [127:0] a, b, c, det, cof;
        logic [127:0]        dmag, cmag, quo;
        logic [31:0]         r [9];
        bit                  dneg, neg;
        v = m;
        for (int k = 0; k < 9; k++)
            s[k] = v[(8 - k) * 32 +: 32];
        det = '0;
        for (int k = 0; k < 6; k++)
        begin
            a = s[SARRUS[k][0]];
            b = s[SARRUS[k][1]];
            c = s[SARRUS[k][2]];
            if (k < 3)
                det = det + a * b * c;
            else
                det = det - a * b * c;
        end
        if (det == 0)
            return '0;
        dneg = det < 0;
        dmag = dneg ? -det : det;
        for (int k = 0; k < 9; k++)
        begin
            a = s[mi3_pkg::COF_TERMS[k][0]];
            b = s[mi3_pkg::COF_TERMS[k][1]];
            c = s[mi3_pkg::COF_TERMS[k][2]];
            cof = a * b - c * s[mi3_pkg::COF_TERMS[k][3]];
            neg = (cof < 0) != dneg;
            cmag = cof < 0 ? -cof : cof;
            quo = (cmag << 32) / dmag;
            if (neg)
                r[k] = (quo > 128'h8000_0000) ? MINV : 32'(-quo);
            else
                r[k] = (quo > 128'h7FFF_FFFF) ? MAXV : quo[31:0];
        end
        return pack_inv(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b1);
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(3))
            0: return $urandom_range(32'h0002_0000);
            1: return -$urandom_range(32'h0002_0000);
            2: return $urandom_range(1) ? MAXV - $urandom_range(3) : MINV + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic mi3_pkg::in_item_t random_matrix();
        logic [31:0] e [9];
        int          kind;
        kind = $urandom_range(9);
        for (int k = 0; k < 9; k++)
            e[k] = (kind < 3) ? $urandom : rand_entry();
        if (kind == 7)
            for (int k = 0; k < 3; k++)
                e[6 + k] = e[k];                 // repeated column: singular
        else if (kind == 8)
            for (int k = 0; k < 9; k++)
                if (k % 4 != 0)
                    e[k] = '0;                   // diagonal
        return pack_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
    endfunction

    task automatic send_matrix(mi3_pkg::in_item_t m);
        int idle;
        idle = (phase == 0) ? 30 : (phase == 1) ? 48 : 0;
        mat_valid <= 1'b1;
        mat       <= m;
        @(posedge clk);
        while (mat_stall)
            @(posedge clk);
        inverse_q.push_back(predict_inverse(m));
        while ($urandom_range(99) < idle)
        begin
            mat_valid <= 1'b0;
            mat       <= ~m;
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        int stall_pct;
        stall_pct = (phase == 0) ? 48 : (phase == 1) ? 30 : 0;
        inv_stall <= ($urandom_range(99) < stall_pct);
    end

    // output checker
    always @(posedge clk)
    begin
        mi3_pkg::out_item_t want;
        logic [288:0]       wv, gv;
        if (rst_n && inv_valid && !inv_stall)
        begin
            if (inverse_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected inverse item %h", inv);
            end
            else
            begin
                want = inverse_q.pop_front();
                wv = want;
                gv = inv;
                for (int k = 0; k < 10; k++)
                begin
                    if ((k < 9 && wv[288 - k * 32 -: 32] !== gv[288 - k * 32 -: 32])
                        || (k == 9 && wv[0] !== gv[0]))
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            if (k < 9)
                                $display("entry c%0d_r%0d: expected %h got %h", k / 3, k % 3,
                                         wv[288 - k * 32 -: 32], gv[288 - k * 32 -: 32]);
                            else
                                $display("invertible: expected %b got %b", wv[0], gv[0]);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_matrix3_inverse: done, errors");
        $finish;
    end

    initial
    begin
        row_t rows [$];
        int   drain;
        errors    = 0;
        phase     = 0;
        rst_n     = 1'b0;
        mat_valid = 1'b0;
        mat       = '0;
        rows.push_back('{pack_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1,
                         pack_inv(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b1)});
        rows.push_back('{pack_mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        rows.push_back('{pack_mat(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV),
                         1'b1, '0});
        rows.push_back('{pack_mat(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV),
                         1'b1, '0});
        rows.push_back('{pack_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1'b1,
                         pack_inv(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE, 1'b1)});
        // tiny determinant: raw 1 on the diagonal saturates but stays invertible
        rows.push_back('{pack_mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
                         pack_inv(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV, 1'b1)});
        rows.push_back('{pack_mat(-1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
                         pack_inv(MINV, 0, 0, 0, MAXV, 0, 0, 0, MAXV, 1'b1)});
        rows.push_back('{pack_mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV), 1'b0, '0});
        rows.push_back('{pack_mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV), 1'b0, '0});
        rows.push_back('{pack_mat(MINV, MAXV, 0, 0, MINV, MAXV, MAXV, 0, MINV), 1'b0, '0});
        rows.push_back('{pack_mat(2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE),
                         1'b0, '0});
        rows.push_back('{pack_mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 1'b0, '0});
        rows.push_back('{pack_mat(3, 5, 7, 11, 13, 17, 19, 23, 29), 1'b0, '0});
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            if (rows[i].known && predict_inverse(rows[i].m) !== rows[i].want)
            begin
                errors++;
                $display("table row %0d: predictor disagrees with typed result", i);
            end
            send_matrix(rows[i].m);
        end
        for (phase = 0; phase < 3; phase++)
            for (int n = 0; n < 380; n++)
                send_matrix(random_matrix());
        mat_valid <= 1'b0;
        drain = 0;
        while (inverse_q.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (60) @(posedge clk);
        if (errors == 0 && inverse_q.size() == 0)
            $display("tb_matrix3_inverse: done, clean");
        else
            $display("tb_matrix3_inverse: done, errors");
        $finish;
    end

endmodule
